@@ sv/kmd_pkg.sv @@
// ----------------------------------------------------------------------------
// kmd_pkg
// Shared sizes, register codes and state types of the key matrix debouncer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kmd_pkg;

  // Matrix geometry and time base
  localparam int ROWS      = 5;
  localparam int COLS      = 3;
  localparam int TIME_BITS = 32;
  localparam int NKEYS     = ROWS * COLS;

  localparam int COL_W   = 2;                 // width of column_index
  localparam int LVL_W   = 5;                 // width of row_levels
  localparam int KEY_W   = 4;                 // width of key_index
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ADDR_W  = (COLS > 1) ? $clog2(COLS) : 1;

  // Configuration registers
  localparam int DEB_W       = 16;
  localparam int MASK_W      = 15;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;
  localparam logic [DEB_W-1:0]  DEB_RESET  = 16'd20;
  localparam logic [MASK_W-1:0] MASK_RESET = 15'd32383;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_MS = 1'b0,
    REG_KEY_MASK    = 1'b1
  } cfg_reg_e;

  // Stream payload widths
  localparam int IN_TDATA_W  = 40;            // col + levels + time, byte filled
  localparam int OUT_TDATA_W = 8;             // key index, byte filled

  // Per-key state word
  typedef struct packed {
    logic                 raw;
    logic                 steady;
    logic [TIME_BITS-1:0] stamp;
  } key_state_t;

  // One memory entry holds a whole column
  typedef key_state_t [ROWS-1:0] col_entry_t;

  // Result of one key update
  typedef struct packed {
    key_state_t st;
    logic       evt;
  } lane_res_t;

endpackage : kmd_pkg

`default_nettype wire

@@ sv/kmd_lane.sv @@
// ----------------------------------------------------------------------------
// kmd_lane
// Debounce update for one key: restart its timer on a raw level change,
// commit the steady level once the delay has passed, flag a level event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmd_lane (
  input  kmd_pkg::key_state_t               st_i,
  input  logic                              connected_i,
  input  logic                              level_i,
  input  logic [kmd_pkg::TIME_BITS-1:0]     now_i,
  input  logic [kmd_pkg::DEB_W-1:0]         debounce_i,
  output kmd_pkg::lane_res_t                res_o
);
  import kmd_pkg::*;

  logic [TIME_BITS-1:0] stamp;
  logic [TIME_BITS-1:0] elapsed;
  logic                 settled;

  assign stamp   = (level_i != st_i.raw) ? now_i : st_i.stamp;
  assign elapsed = now_i - stamp;
  assign settled = elapsed > TIME_BITS'(debounce_i);

  always_comb begin
    res_o.st  = st_i;
    res_o.evt = 1'b0;
    if (connected_i) begin
      res_o.st.raw   = level_i;
      res_o.st.stamp = stamp;
      if (settled) begin
        res_o.st.steady = level_i;
        res_o.evt       = (st_i.steady != level_i);
      end
    end
  end

endmodule : kmd_lane

`default_nettype wire

@@ sv/keypad_matrix_debouncer_top.sv @@
// ----------------------------------------------------------------------------
// keypad_matrix_debouncer_top
// Key matrix debouncer with per-column state memory and event stream output.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one column sample per transfer (column, row levels, time).
//   Master stream: one key event per transfer (key index, press flag), with
//   tlast on the final event of a sample. A sample that changes no steady
//   level produces no transfer.
//   Config port: write debounce delay (index 0) or key mask (index 1) while
//   the block is idle; writes take effect at the next edge.
// Timing:
//   The first event of a sample passes the column stage, the event serializer
//   and the output register. Samples are taken back to back while the event
//   serializer keeps up; it sends one event per cycle unless the receiver
//   stalls, up to five per sample, and holds the column stage until the last.
//   Key state of a column sits in one memory word, read on accept and written
//   back when the column stage advances; a read that meets the write of the
//   same column takes the forwarded word.
// Reset:
//   Clears all key state (per-column valid bits, no clearing pass), restores
//   the register defaults and empties the pipeline.
// Stall:
//   When the receiver holds tready low, the output word and pending events
//   hold, then the column stage holds, then tready on the input drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keypad_matrix_debouncer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample stream: [1:0] column_index, [6:2] row_levels, [38:7] now_ms
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [kmd_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // event stream: [3:0] key_index
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [kmd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // [0] pressed
  output logic                                m_axis_tuser_o,
  // last_event
  output logic                                m_axis_tlast_o,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [kmd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [kmd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import kmd_pkg::*;

  // ---------------- configuration registers ----------------
  logic [DEB_W-1:0]  deb_q;
  logic [MASK_W-1:0] mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q  <= DEB_RESET;
      mask_q <= MASK_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DEBOUNCE_MS: deb_q  <= cfg_wdata_i[DEB_W-1:0];
        REG_KEY_MASK:    mask_q <= cfg_wdata_i[MASK_W-1:0];
        default:         ;
      endcase
    end
  end

  // ---------------- input unpack ----------------
  logic [COL_W-1:0]     in_col;
  logic [ROWS-1:0]      in_lvl;
  logic [TIME_BITS-1:0] in_now;
  logic                 in_col_ok;
  logic                 in_fire;

  assign in_col    = s_axis_tdata_i[COL_W-1:0];
  assign in_lvl    = s_axis_tdata_i[COL_W +: ROWS];
  assign in_now    = s_axis_tdata_i[COL_W+LVL_W +: TIME_BITS];
  assign in_col_ok = in_col < COL_W'(COLS);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------- column stage ----------------
  logic                 s1_valid_q;
  logic [COL_W-1:0]     s1_col_q;
  logic                 s1_col_ok_q;
  logic [ROWS-1:0]      s1_lvl_q;
  logic [TIME_BITS-1:0] s1_now_q;
  logic                 s1_hit_q;
  col_entry_t           s1_fwd_q;
  logic                 s1_ent_valid_q;
  col_entry_t           rd_data_q;
  logic                 s1_fire;
  logic                 emit_free;

  // write-back port
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  col_entry_t           wr_data;

  col_entry_t           state_mem [COLS];
  logic [COLS-1:0]      col_valid_q;

  assign s1_fire         = s1_valid_q && emit_free;
  assign s_axis_tready_o = !s1_valid_q || s1_fire;
  assign wr_en           = s1_fire && s1_col_ok_q;
  assign wr_addr         = s1_col_q[ADDR_W-1:0];

  // memory: one word per column, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      state_mem[wr_addr] <= wr_data;
    end
    if (in_fire && in_col_ok) begin
      rd_data_q <= state_mem[in_col[ADDR_W-1:0]];
    end
  end

  // valid bit per word: unwritten words read as all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_valid_q <= '0;
    end else if (wr_en) begin
      col_valid_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_col_q       <= in_col;
      s1_col_ok_q    <= in_col_ok;
      s1_lvl_q       <= in_lvl;
      s1_now_q       <= in_now;
      // forward the word written at the same edge as the read
      s1_hit_q       <= wr_en && (wr_addr == in_col[ADDR_W-1:0]);
      s1_fwd_q       <= wr_data;
      s1_ent_valid_q <= in_col_ok ? col_valid_q[in_col[ADDR_W-1:0]] : 1'b0;
    end
  end

  col_entry_t cur_ent;
  assign cur_ent = s1_hit_q       ? s1_fwd_q  :
                   s1_ent_valid_q ? rd_data_q : '0;

  // one update lane per row
  lane_res_t       lane_res [ROWS];
  logic [ROWS-1:0] ev_mask;

  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    logic [KEY_W-1:0] key_idx;
    logic             conn;

    assign key_idx = KEY_W'(r * COLS) + KEY_W'(s1_col_q);
    assign conn    = (key_idx < KEY_W'(MASK_W)) ? mask_q[key_idx] : 1'b0;

    kmd_lane u_lane (
      .st_i        (cur_ent[r]),
      .connected_i (conn),
      .level_i     (s1_lvl_q[r]),
      .now_i       (s1_now_q),
      .debounce_i  (deb_q),
      .res_o       (lane_res[r])
    );

    assign wr_data[r] = lane_res[r].st;
    assign ev_mask[r] = lane_res[r].evt && s1_col_ok_q;
  end

  // ---------------- event serializer ----------------
  logic [ROWS-1:0]  emit_mask_q;
  logic [ROWS-1:0]  emit_press_q;
  logic [COL_W-1:0] emit_col_q;
  logic [ROW_W-1:0] sel_row;
  logic [ROWS-1:0]  remain;
  logic             out_free;
  logic             pop;

  // pick the lowest pending row
  always_comb begin
    sel_row = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (emit_mask_q[r]) begin
        sel_row = ROW_W'(r);
      end
    end
    remain = emit_mask_q & ~(ROWS'(1) << sel_row);
  end

  logic out_valid_q;
  logic [KEY_W-1:0] out_key_q;
  logic out_press_q;
  logic out_last_q;

  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign pop       = (emit_mask_q != '0) && out_free;
  assign emit_free = (emit_mask_q == '0) || (pop && (remain == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_mask_q <= '0;
    end else if (s1_fire) begin
      emit_mask_q <= ev_mask;
    end else if (pop) begin
      emit_mask_q <= remain;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      emit_press_q <= s1_lvl_q;
      emit_col_q   <= s1_col_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_key_q   <= KEY_W'(sel_row * KEY_W'(COLS)) + KEY_W'(emit_col_q);
      out_press_q <= emit_press_q[sel_row];
      out_last_q  <= (remain == '0);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_key_q);
  assign m_axis_tuser_o  = out_press_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule : keypad_matrix_debouncer_top

`default_nettype wire

@@ sv/kmd_checker.sv @@
// ----------------------------------------------------------------------------
// kmd_checker
// Port-level checks of the key matrix debouncer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmd_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  input  logic [kmd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  input  logic                                m_axis_tuser_o,
  input  logic                                m_axis_tlast_o
);
  import kmd_pkg::*;

  logic             out_acc;
  logic [KEY_W-1:0] key;
  logic             key_ok;
  logic             run_q;
  logic [KEY_W-1:0] prev_key_q;
  logic [NKEYS-1:0] press_q;
  logic             prev_press;

  assign out_acc    = m_axis_tvalid_o && m_axis_tready_i;
  assign key        = m_axis_tdata_o[KEY_W-1:0];
  assign key_ok     = key < KEY_W'(NKEYS);
  assign prev_press = key_ok ? press_q[key] : 1'b0;

  // track position within a sample's events and each key's last event kind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 1'b0;
      prev_key_q <= '0;
      press_q    <= '0;
    end else if (out_acc) begin
      run_q      <= !m_axis_tlast_o;
      prev_key_q <= key;
      if (key_ok) begin
        press_q[key] <= m_axis_tuser_o;
      end
    end
  end

  // held event does not change while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o &&
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("event changed while stalled");

  // nothing is offered while reset is held
  a_rst: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("event offered during reset");

  // events of one sample come in ascending row order, valid key range
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> key_ok && (!run_q || (key > prev_key_q)))
    else $error("event key out of order or out of range");

  // a key alternates press and release, starting with a press
  a_alt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && key_ok |-> m_axis_tuser_o != prev_press)
    else $error("key event kind repeated");

endmodule : kmd_checker

bind keypad_matrix_debouncer_top kmd_checker u_kmd_checker (.*);

`default_nettype wire

@@ tb/keypad_matrix_debouncer_top_test.sv @@
// ----------------------------------------------------------------------------
// keypad_matrix_debouncer_top_test
// Self-checking bench for the key matrix debouncer: column samples go in on
// the sample stream, and a behavioral debouncer inside the bench predicts
// every press and release event. Each event on the output stream is compared
// in order with that prediction. Directed samples come first, then a forced
// output stall and random scan traffic under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_matrix_debouncer_top_test;
  import kmd_pkg::*;

  localparam int DRAIN_CYCLES   = 8;     // generous over the pipeline latency
  localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transfer
  localparam int PAD_W          = IN_TDATA_W - COL_W - LVL_W - TIME_BITS;

  // One predicted key event
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             pressed;
    logic             closes_scan;
  } key_event_t;

  // DUT connections
  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  // [1:0] column_index, [6:2] row_levels, [38:7] now_ms, [39] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  // [3:0] key_index, [7:4] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  // [0] pressed
  logic                   m_axis_tuser_o;
  logic                   m_axis_tlast_o;
  logic                   cfg_we_i;
  cfg_reg_e               cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;

  // Debouncer state as the bench sees it
  logic                 raw_seen [NKEYS];
  logic                 steady   [NKEYS];
  logic [TIME_BITS-1:0] stamp_ms [NKEYS];
  logic [DEB_W-1:0]     debounce_q = DEB_RESET;
  logic [MASK_W-1:0]    mask_q     = MASK_RESET;

  key_event_t pending_events[$];
  int         mismatches       = 0;
  int         src_max_gap      = 11;
  int         snk_max_stall    = 11;
  int         sink_hold_cycles = 0;
  int         stall_left       = 0;
  int         idle_cycles      = 0;

  keypad_matrix_debouncer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // 100 MHz clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Event prediction: walk the connected keys of the sampled column from row 0
  // upward, restart a key's timer on a raw level change, and once the wrapping
  // elapsed time beats the delay take the level as steady. Only a change of
  // the steady level yields an event; the last one of the sample closes it.
  // --------------------------------------------------------------------------
  function automatic void predict_events(input logic [COL_W-1:0]     col,
                                         input logic [LVL_W-1:0]     rows,
                                         input logic [TIME_BITS-1:0] ms);
    logic [KEY_W-1:0]     ev_key [ROWS];
    logic                 ev_lvl [ROWS];
    logic [TIME_BITS-1:0] elapsed;
    logic                 lvl;
    int                   k;
    int                   n;
    key_event_t           ev;
    n = 0;
    // out-of-range columns leave every key alone
    if (int'(col) >= COLS) return;
    for (int r = 0; r < ROWS; r++) begin
      k = r * COLS + int'(col);
      // keys without a mask bit count as unconnected
      if (k >= MASK_W || !mask_q[k]) continue;
      lvl = rows[r];
      if (lvl != raw_seen[k]) begin
        stamp_ms[k] = ms;
        raw_seen[k] = lvl;
      end
      elapsed = ms - stamp_ms[k];
      if (elapsed > TIME_BITS'(debounce_q)) begin
        if (steady[k] != lvl) begin
          ev_key[n] = KEY_W'(k);
          ev_lvl[n] = lvl;
          n++;
        end
        // rewritten even when unchanged, without an event
        steady[k] = lvl;
      end
    end
    for (int i = 0; i < n; i++) begin
      ev.key         = ev_key[i];
      ev.pressed     = ev_lvl[i];
      ev.closes_scan = (i == n - 1);
      pending_events.push_back(ev);
    end
  endfunction

  // Predict on every accepted sample, then check every accepted event
  always @(posedge clk_i) begin : scoreboard
    key_event_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        predict_events(s_axis_tdata_i[COL_W-1:0], s_axis_tdata_i[COL_W +: LVL_W],
                       s_axis_tdata_i[COL_W+LVL_W +: TIME_BITS]);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected event: key %0d pressed %0b last %0b", $time,
                   m_axis_tdata_o[KEY_W-1:0], m_axis_tuser_o, m_axis_tlast_o);
          mismatches++;
        end else begin
          want = pending_events.pop_front();
          if (want.key != m_axis_tdata_o[KEY_W-1:0] || want.pressed != m_axis_tuser_o ||
              want.closes_scan != m_axis_tlast_o) begin
            $display({"%0t: event mismatch: expected key %0d pressed %0b last %0b, ",
                      "got key %0d pressed %0b last %0b"},
                     $time, want.key, want.pressed, want.closes_scan,
                     m_axis_tdata_o[KEY_W-1:0], m_axis_tuser_o, m_axis_tlast_o);
            mismatches++;
          end
        end
      end
    end
  end

  // Event receiver: random stall after each transfer, or a long hold-off
  // while sink_hold_cycles counts down
  always @(posedge clk_i) begin
    if (sink_hold_cycles > 0) begin
      sink_hold_cycles--;
      m_axis_tready_i <= 1'b0;
    end else if (m_axis_tready_i && m_axis_tvalid_o) begin
      stall_left = $urandom_range(0, snk_max_stall);
      if (stall_left > 0) m_axis_tready_i <= 1'b0;
    end else if (!m_axis_tready_i) begin
      if (stall_left > 0) stall_left--;
      if (stall_left == 0) m_axis_tready_i <= 1'b1;
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        cfg_we_i)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d events outstanding", $time,
               pending_events.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one column sample after a random gap; return at the accepting edge
  // with tvalid still high so back-to-back transfers need no extra step
  task automatic send_sample(input logic [COL_W-1:0]     col,
                             input logic [LVL_W-1:0]     rows,
                             input logic [TIME_BITS-1:0] ms);
    int gap;
    gap = $urandom_range(0, src_max_gap);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{PAD_W{1'b0}}, ms, rows, col};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Drop tvalid, wait for all predicted events, then let the pipe drain
  // samples that produce no event
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register write; the mirror follows at once since the block is idle
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      REG_DEBOUNCE_MS: debounce_q = value[DEB_W-1:0];
      REG_KEY_MASK:    mask_q     = value[MASK_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reset defaults: 20 ms delay and the two unconnected keys of row 2
  task automatic test_reset_defaults();
    send_sample(2'd0, 5'h1F, 32'd0);           // raw change only
    send_sample(2'd0, 5'h1F, 32'd20);          // elapsed equals delay: hold
    send_sample(2'd0, 5'h1F, 32'd21);          // five presses
    send_sample(2'd2, 5'h1F, 32'd100);
    send_sample(2'd2, 5'h1F, 32'd121);         // key 8 is masked out
    send_sample(2'd3, 5'h1F, 32'd130);         // column out of range
    send_sample(2'd1, 5'h1F, 32'hFFFF_FFF0);
    send_sample(2'd1, 5'h1F, 32'h0000_0005);   // elapsed wraps through zero
    send_sample(2'd0, 5'h00, 32'hFFFF_FFFF);
    send_sample(2'd0, 5'h00, 32'h0000_0014);   // releases after the wrap
    send_sample(2'd0, 5'h00, 32'h0000_0040);   // steady already, no event
  endtask

  // Register extremes: zero and full delay, empty and full mask
  task automatic test_config_extremes();
    wait_idle();
    write_reg(REG_DEBOUNCE_MS, 16'd0);
    write_reg(REG_KEY_MASK, 16'hFFFF);         // bit 15 is dropped
    send_sample(2'd1, 5'h15, 32'd1000);
    send_sample(2'd1, 5'h15, 32'd1000);        // zero elapsed: nothing yet
    send_sample(2'd1, 5'h15, 32'd1001);
    wait_idle();
    write_reg(REG_DEBOUNCE_MS, 16'hFFFF);
    send_sample(2'd2, 5'h00, 32'd2000);
    send_sample(2'd2, 5'h00, 32'd2000 + 32'd65535);
    send_sample(2'd2, 5'h00, 32'd2000 + 32'd65536);
    wait_idle();
    write_reg(REG_KEY_MASK, 16'h0000);
    send_sample(2'd0, 5'h1F, 32'd500_000);
    send_sample(2'd0, 5'h1F, 32'd600_000);
  endtask

  // Hold the receiver off while full-column toggles keep arriving back to
  // back, so the event path fills and the sample input stalls
  task automatic test_output_stall();
    logic [LVL_W-1:0] rows;
    wait_idle();
    write_reg(REG_DEBOUNCE_MS, 16'd0);
    write_reg(REG_KEY_MASK, 16'h7FFF);
    src_max_gap      = 0;
    sink_hold_cycles = 400;
    for (int i = 0; i < 30; i++) begin
      rows = ((i / 3) % 4 < 2) ? 5'h1F : 5'h00;
      send_sample(COL_W'(i % COLS), rows, 32'd5000 + 32'(i));
    end
    src_max_gap = 11;
  endtask

  // Random scanning: each column follows a held key pattern that changes now
  // and then, with bounce noise, stray columns and occasional time jumps
  task automatic scan_phase(input int n_items, input logic [CFG_DATA_W-1:0] delay,
                            input logic [CFG_DATA_W-1:0] mask_word,
                            input logic [TIME_BITS-1:0] start_ms, input int max_idle);
    logic [LVL_W-1:0]     held [COLS];
    logic [LVL_W-1:0]     rows;
    logic [COL_W-1:0]     col;
    logic [TIME_BITS-1:0] ms;
    int                   done;
    wait_idle();
    write_reg(REG_DEBOUNCE_MS, delay);
    write_reg(REG_KEY_MASK, mask_word);
    src_max_gap   = max_idle;
    snk_max_stall = max_idle;
    ms   = start_ms;
    done = 0;
    for (int c = 0; c < COLS; c++) held[c] = LVL_W'($urandom_range(0, 31));
    while (done < n_items) begin
      if ($urandom_range(0, 15) == 0)
        ms = $urandom();
      else
        ms += TIME_BITS'($urandom_range(0, int'(debounce_q) / 2 + 2));
      if ($urandom_range(0, 9) == 0) begin
        col  = COL_W'(COLS);
        rows = LVL_W'($urandom_range(0, 31));
      end else begin
        col = COL_W'($urandom_range(0, COLS - 1));
        if ($urandom_range(0, 4) == 0) held[col] = LVL_W'($urandom_range(0, 31));
        rows = held[col];
        // contact bounce
        if ($urandom_range(0, 3) == 0) rows ^= LVL_W'($urandom_range(1, 31));
        done++;
      end
      send_sample(col, rows, ms);
    end
  endtask

  task automatic test_random_scans();
    scan_phase(40, 16'd20, 16'(MASK_RESET), 32'd10_000, 11);
    scan_phase(35, 16'd0, 16'h7FFF, 32'd20_000, 0);
    scan_phase(35, 16'd3, 16'($urandom_range(0, 65535)), 32'd30_000, 11);
    scan_phase(30, 16'hFFFF, 16'h7FFF, 32'hFFFF_0000, 11);
  endtask

  initial begin
    for (int k = 0; k < NKEYS; k++) begin
      raw_seen[k] = 1'b0;
      steady[k]   = 1'b0;
      stamp_ms[k] = '0;
    end
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= REG_DEBOUNCE_MS;
    cfg_wdata_i     <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_config_extremes();
    test_output_stall();
    test_random_scans();

    wait_idle();
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
